### rtl/assert_macros.svh
// Assertion macros for the checker module of the line table encoder.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LIDE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: lbl");

// Condition must never be true at a clock edge outside reset.
`define LIDE_NEVER(lbl, clk, rst_n, cond) \
    `LIDE_ASSERT(lbl, clk, rst_n, !(cond))

`endif

### rtl/lide_pkg.sv
// Package for the line table encoder: controller states, value part codes
// and the command and status structs between controller and datapath.
`default_nettype none

package lide_pkg;

    // Codes carried on the value part output.
    localparam logic [1:0] PART_OFFSET = 2'd0;
    localparam logic [1:0] PART_LINE   = 2'd1;
    localparam logic [1:0] PART_COLUMN = 2'd2;

    // Offset value that stands for "no offset" and counts as zero.
    localparam logic [31:0] OFFSET_NONE = 32'hFFFF_FFFF;

    // Controller states.
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture deltas of the accepted item, record it
        logic shift;      // drop the low 7-bit group of the current value
        logic next_part;  // move on to the next of the three values
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic enabled;    // line information output is enabled
        logic changed;    // input line or column differs from the recorded pair
        logic more;       // current value needs further bytes after this one
        logic last_part;  // current value is the column delta
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/lide_ctrl.sv
// Controller state machine of the line table encoder.
// Depends on lide_pkg; drives the datapath commands and both handshakes.
`default_nettype none

module lide_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  wire lide_pkg::t_dp_sts i_sts,
    output lide_pkg::t_dp_cmd o_cmd
);

    lide_pkg::t_state r_state;
    lide_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lide_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state, handshakes and datapath commands.
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            lide_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                // An item that produces no record is simply consumed.
                if (i_in_valid && i_sts.enabled && i_sts.changed) begin
                    o_cmd.load = 1'b1;
                    n_state    = lide_pkg::ST_EMIT;
                end
            end
            lide_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.more) begin
                        o_cmd.shift = 1'b1;
                    end else if (i_sts.last_part) begin
                        n_state = lide_pkg::ST_IDLE;
                    end else begin
                        o_cmd.next_part = 1'b1;
                    end
                end
            end
            default: begin
                n_state = lide_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/lide_dp.sv
// Datapath of the line table encoder: recorded pair, delta and zigzag
// logic, and the varint shift register. Depends on lide_pkg.
`default_nettype none

module lide_dp (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire               i_cfg_wdata,
    input  wire  [31:0]       i_node_offset,
    input  wire  [30:0]       i_line_number,
    input  wire  [30:0]       i_column_number,
    input  wire lide_pkg::t_dp_cmd i_cmd,
    output lide_pkg::t_dp_sts o_sts,
    output logic [7:0]        o_out_byte,
    output logic [1:0]        o_value_part,
    output logic              o_last_of_record
);

    logic        r_enable;
    logic [31:0] r_prev_offset;
    logic [30:0] r_prev_line;
    logic [30:0] r_prev_column;
    logic [31:0] r_value;
    logic [31:0] r_line_zz;
    logic [31:0] r_col_zz;
    logic [1:0]  r_part;

    logic [31:0] n_offset;
    logic [31:0] n_off_delta;
    logic [31:0] n_line_delta;
    logic [31:0] n_col_delta;
    logic [31:0] n_line_zz;
    logic [31:0] n_col_zz;

    // Deltas of the incoming item against the recorded pair.
    always_comb begin
        n_offset     = (i_node_offset == lide_pkg::OFFSET_NONE) ? 32'd0 : i_node_offset;
        n_off_delta  = n_offset - r_prev_offset;
        n_line_delta = {1'b0, i_line_number} - {1'b0, r_prev_line};
        n_col_delta  = {1'b0, i_column_number} - {1'b0, r_prev_column};
        n_line_zz    = {n_line_delta[30:0], 1'b0} ^ {32{n_line_delta[31]}};
        n_col_zz     = {n_col_delta[30:0], 1'b0} ^ {32{n_col_delta[31]}};
    end

    // Enable register and recorded pair; the pair updates when a record starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= 1'b0;
            r_prev_offset <= '0;
            r_prev_line   <= '0;
            r_prev_column <= '0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_prev_offset <= n_offset;
                r_prev_line   <= i_line_number;
                r_prev_column <= i_column_number;
            end
        end
    end

    // Varint shift register and part counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_part <= lide_pkg::PART_OFFSET;
        end else if (i_cmd.load) begin
            r_part <= lide_pkg::PART_OFFSET;
        end else if (i_cmd.next_part) begin
            r_part <= r_part + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value   <= n_off_delta;
            r_line_zz <= n_line_zz;
            r_col_zz  <= n_col_zz;
        end else if (i_cmd.shift) begin
            r_value <= {7'd0, r_value[31:7]};
        end else if (i_cmd.next_part) begin
            r_value <= (r_part == lide_pkg::PART_OFFSET) ? r_line_zz : r_col_zz;
        end
    end

    // Status toward the controller.
    always_comb begin
        o_sts.enabled   = r_enable;
        o_sts.changed   = (i_line_number != r_prev_line) || (i_column_number != r_prev_column);
        o_sts.more      = |r_value[31:7];
        o_sts.last_part = (r_part == lide_pkg::PART_COLUMN);
    end

    // Output byte: low group with the continuation bit on top.
    assign o_out_byte       = {o_sts.more, r_value[6:0]};
    assign o_value_part     = r_part;
    assign o_last_of_record = !o_sts.more && o_sts.last_part;

endmodule

`default_nettype wire

### rtl/line_info_delta_varint_encoder.sv
// Top level of the line table encoder: joins the controller and datapath.
// Depends on lide_pkg, lide_ctrl and lide_dp.
//
// Each accepted node either produces nothing (output disabled, or line and
// column equal to the recorded pair) or a record of three LEB128 varints:
// offset delta, zigzag line delta and zigzag column delta, low group first.
// The single 32-bit varint shift register sets the rate: one output byte
// per cycle while i_out_ready is high, so a record takes 3 to 15 transfers;
// input is taken again in the cycle after a record's last byte transfers.
// An item without a record makes no output. The enable register resets to
// 0; the user writes it only while no record is in progress (unenforced).
`default_nettype none

module line_info_delta_varint_encoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_wdata,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [31:0] i_node_offset,
    input  wire  [30:0] i_line_number,
    input  wire  [30:0] i_column_number,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_value_part,
    output logic        o_last_of_record
);

    lide_pkg::t_dp_cmd cmd;
    lide_pkg::t_dp_sts sts;

    // Sequencing of accepts and output bytes.
    lide_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Recorded state, deltas and the varint shifter.
    lide_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_node_offset    (i_node_offset),
        .i_line_number    (i_line_number),
        .i_column_number  (i_column_number),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_byte       (o_out_byte),
        .o_value_part     (o_value_part),
        .o_last_of_record (o_last_of_record)
    );

endmodule

`default_nettype wire

### rtl/lide_checker.sv
// Port-level checker for the line table encoder, bound to the top level.
// Depends on assert_macros.svh and lide_pkg.
`default_nettype none
`include "assert_macros.svh"

module lide_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_in_ready,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [7:0]  o_out_byte,
    input wire [1:0]  o_value_part,
    input wire        o_last_of_record
);

    // No new node is taken while a record is still being sent.
    `LIDE_NEVER(a_no_accept_during_record, i_clk, i_rst_n, o_out_valid && o_in_ready)

    // The value part code never takes the unused fourth value.
    `LIDE_NEVER(a_part_in_range, i_clk, i_rst_n, o_out_valid && (o_value_part == 2'd3))

    // The last byte of a record ends the column varint.
    `LIDE_ASSERT(a_last_is_column_end, i_clk, i_rst_n,
        (o_out_valid && o_last_of_record) |->
        (!o_out_byte[7] && (o_value_part == lide_pkg::PART_COLUMN)))

    // After the final byte transfers, the output goes quiet and input reopens.
    `LIDE_ASSERT(a_idle_after_record, i_clk, i_rst_n,
        (o_out_valid && i_out_ready && o_last_of_record) |=> (!o_out_valid && o_in_ready))

    // A waiting output byte holds until it transfers.
    `LIDE_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_byte)))

endmodule

bind line_info_delta_varint_encoder lide_checker u_lide_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_byte       (o_out_byte),
    .o_value_part     (o_value_part),
    .o_last_of_record (o_last_of_record)
);

`default_nettype wire
